[design/nrth_pkg.sv]
// ============================================================================
// nrth_pkg
// Shared widths, operand codes and the multiply sequence of the ray/triangle
// hit core.
// ============================================================================
`default_nettype none

package nrth_pkg;

    localparam int COORD_W  = 32;
    localparam int FRAC_W   = 16;
    localparam int EDGE_W   = COORD_W + 1;
    localparam int WIDE_W   = 52;
    localparam int XMAG_W   = WIDE_W - 1;
    localparam int YLO_W    = 17;
    localparam int YHI_W    = EDGE_W - YLO_W;
    localparam int PACC_W   = XMAG_W + YHI_W;
    localparam int PROD_W   = XMAG_W + EDGE_W;
    localparam int PSH_W    = PROD_W - FRAC_W;
    localparam int CLAMP_W  = 60;
    localparam int ACC_W    = 64;
    localparam int DIST_W   = 31;
    localparam int BEST_W   = 32;
    localparam int QINT_W   = DIST_W - FRAC_W;
    localparam int N_STEPS  = 24;
    localparam int STEP_W   = 5;
    localparam int DIVC_W   = 5;
    localparam int N_REGS   = 6;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [3:0] {
        X_D0, X_D1, X_D2, X_S0, X_S1, X_S2,
        X_H0, X_H1, X_H2, X_Q0, X_Q1, X_Q2
    } t_xsel;

    typedef enum logic [3:0] {
        Y_D0, Y_D1, Y_D2, Y_E1_0, Y_E1_1, Y_E1_2,
        Y_E2_0, Y_E2_1, Y_E2_2, Y_S0, Y_S1, Y_S2
    } t_ysel;

    typedef enum logic [3:0] {
        DST_NONE, DST_H0, DST_H1, DST_H2, DST_Q0, DST_Q1, DST_Q2,
        DST_DET, DST_NU, DST_NV, DST_NT
    } t_dst;

    typedef struct packed {
        t_xsel x;
        t_ysel y;
        logic  sub;
        logic  first;
        t_dst  dst;
    } t_uop;

    typedef struct packed {
        logic              load;
        logic              mul_hi;
        logic              mul_lo;
        logic              acc;
        logic              flip;
        logic              div_init;
        logic              div_step;
        logic              sat;
        logic              update;
        logic              emit;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic pass;
        logic ovf;
        logic last;
    } t_dp_stat;

    function automatic t_uop f_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        u = '{x: X_D0, y: Y_D0, sub: 1'b0, first: 1'b0, dst: DST_NONE};
        case (step)
            5'd0:  u = '{X_D1, Y_E2_2, 1'b0, 1'b1, DST_NONE};
            5'd1:  u = '{X_D2, Y_E2_1, 1'b1, 1'b0, DST_H0};
            5'd2:  u = '{X_D2, Y_E2_0, 1'b0, 1'b1, DST_NONE};
            5'd3:  u = '{X_D0, Y_E2_2, 1'b1, 1'b0, DST_H1};
            5'd4:  u = '{X_D0, Y_E2_1, 1'b0, 1'b1, DST_NONE};
            5'd5:  u = '{X_D1, Y_E2_0, 1'b1, 1'b0, DST_H2};
            5'd6:  u = '{X_H0, Y_E1_0, 1'b0, 1'b1, DST_NONE};
            5'd7:  u = '{X_H1, Y_E1_1, 1'b0, 1'b0, DST_NONE};
            5'd8:  u = '{X_H2, Y_E1_2, 1'b0, 1'b0, DST_DET};
            5'd9:  u = '{X_H0, Y_S0,   1'b0, 1'b1, DST_NONE};
            5'd10: u = '{X_H1, Y_S1,   1'b0, 1'b0, DST_NONE};
            5'd11: u = '{X_H2, Y_S2,   1'b0, 1'b0, DST_NU};
            5'd12: u = '{X_S1, Y_E1_2, 1'b0, 1'b1, DST_NONE};
            5'd13: u = '{X_S2, Y_E1_1, 1'b1, 1'b0, DST_Q0};
            5'd14: u = '{X_S2, Y_E1_0, 1'b0, 1'b1, DST_NONE};
            5'd15: u = '{X_S0, Y_E1_2, 1'b1, 1'b0, DST_Q1};
            5'd16: u = '{X_S0, Y_E1_1, 1'b0, 1'b1, DST_NONE};
            5'd17: u = '{X_S1, Y_E1_0, 1'b1, 1'b0, DST_Q2};
            5'd18: u = '{X_Q0, Y_D0,   1'b0, 1'b1, DST_NONE};
            5'd19: u = '{X_Q1, Y_D1,   1'b0, 1'b0, DST_NONE};
            5'd20: u = '{X_Q2, Y_D2,   1'b0, 1'b0, DST_NV};
            5'd21: u = '{X_Q0, Y_E2_0, 1'b0, 1'b1, DST_NONE};
            5'd22: u = '{X_Q1, Y_E2_1, 1'b0, 1'b0, DST_NONE};
            5'd23: u = '{X_Q2, Y_E2_2, 1'b0, 1'b0, DST_NT};
            default: u = '{X_D0, Y_D0, 1'b0, 1'b0, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

[design/nrth_datapath.sv]
// ============================================================================
// nrth_datapath
// Ray registers, edge vectors, shared two-pass multiplier with accumulator,
// sign fixup, hit tests, restoring divider and nearest-hit tracking.
// ============================================================================
`default_nettype none

module nrth_datapath import nrth_pkg::*; (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    output t_dp_stat                  o_stat,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire        [ADDR_W-1:0]   paddr,
    input  wire        [DATA_W-1:0]   pwdata,
    output logic       [DATA_W-1:0]   prdata,
    input  wire signed [COORD_W-1:0]  i_a_x,
    input  wire signed [COORD_W-1:0]  i_a_y,
    input  wire signed [COORD_W-1:0]  i_a_z,
    input  wire signed [COORD_W-1:0]  i_b_x,
    input  wire signed [COORD_W-1:0]  i_b_y,
    input  wire signed [COORD_W-1:0]  i_b_z,
    input  wire signed [COORD_W-1:0]  i_c_x,
    input  wire signed [COORD_W-1:0]  i_c_y,
    input  wire signed [COORD_W-1:0]  i_c_z,
    input  wire                       i_last_triangle,
    output logic                      o_hit,
    output logic       [DIST_W-1:0]   o_distance
);

    logic signed [COORD_W-1:0] r_cfg [N_REGS];
    logic signed [EDGE_W-1:0]  r_e1 [3];
    logic signed [EDGE_W-1:0]  r_e2 [3];
    logic signed [EDGE_W-1:0]  r_s  [3];
    logic signed [WIDE_W-1:0]  r_h  [3];
    logic signed [WIDE_W-1:0]  r_q  [3];
    logic signed [ACC_W-1:0]   r_det, r_nu, r_nv, r_nt, r_acc;
    logic                      r_last;
    logic [PACC_W-1:0]         r_pacc;
    logic [PROD_W-1:0]         r_prod;
    logic                      r_neg;
    logic [ACC_W-1:0]          r_rem;
    logic [DIST_W-1:0]         r_dvd;
    logic [DIST_W-1:0]         r_quo;
    logic [BEST_W-1:0]         r_best;
    logic                      r_found;

    logic [2:0]                cfg_idx;
    logic                      cfg_wr;
    t_uop                      uop;
    logic signed [WIDE_W-1:0]  xv;
    logic signed [EDGE_W-1:0]  yv;
    logic [XMAG_W-1:0]         xm;
    logic [EDGE_W-1:0]         ym;
    logic [PSH_W-1:0]          pm;
    logic [CLAMP_W-1:0]        pc;
    logic signed [ACC_W-1:0]   ps;
    logic signed [ACC_W-1:0]   acc_n;
    logic signed [ACC_W:0]     nuv;
    logic [ACC_W-1:0]          div_r2;
    logic                      div_ge;

    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;
    assign prdata  = (cfg_idx < 3'(N_REGS)) ? r_cfg[cfg_idx] : '0;

    assign uop = f_uop(i_cmd.step);

    always_comb begin
        case (uop.x)
            X_D0:    xv = WIDE_W'(r_cfg[3]);
            X_D1:    xv = WIDE_W'(r_cfg[4]);
            X_D2:    xv = WIDE_W'(r_cfg[5]);
            X_S0:    xv = WIDE_W'(r_s[0]);
            X_S1:    xv = WIDE_W'(r_s[1]);
            X_S2:    xv = WIDE_W'(r_s[2]);
            X_H0:    xv = r_h[0];
            X_H1:    xv = r_h[1];
            X_H2:    xv = r_h[2];
            X_Q0:    xv = r_q[0];
            X_Q1:    xv = r_q[1];
            X_Q2:    xv = r_q[2];
            default: xv = '0;
        endcase
        case (uop.y)
            Y_D0:    yv = EDGE_W'(r_cfg[3]);
            Y_D1:    yv = EDGE_W'(r_cfg[4]);
            Y_D2:    yv = EDGE_W'(r_cfg[5]);
            Y_E1_0:  yv = r_e1[0];
            Y_E1_1:  yv = r_e1[1];
            Y_E1_2:  yv = r_e1[2];
            Y_E2_0:  yv = r_e2[0];
            Y_E2_1:  yv = r_e2[1];
            Y_E2_2:  yv = r_e2[2];
            Y_S0:    yv = r_s[0];
            Y_S1:    yv = r_s[1];
            Y_S2:    yv = r_s[2];
            default: yv = '0;
        endcase
    end

    always_comb begin
        xm    = xv[WIDE_W-1] ? XMAG_W'(-xv) : XMAG_W'(xv);
        ym    = yv[EDGE_W-1] ? EDGE_W'(-yv) : EDGE_W'(yv);
        pm    = r_prod[PROD_W-1:FRAC_W];
        pc    = (|pm[PSH_W-1:CLAMP_W]) ? {CLAMP_W{1'b1}} : pm[CLAMP_W-1:0];
        ps    = r_neg ? -$signed(ACC_W'(pc)) : $signed(ACC_W'(pc));
        acc_n = uop.first ? ps : r_acc + ps;
        nuv   = $signed({r_nu[ACC_W-1], r_nu}) + $signed({r_nv[ACC_W-1], r_nv});
        div_r2 = {r_rem[ACC_W-2:0], r_dvd[DIST_W-1]};
        div_ge = div_r2 >= r_det;
    end

    assign o_stat.pass = (r_det != '0) && !r_nu[ACC_W-1] && (r_nu <= r_det)
                      && !r_nv[ACC_W-1] && (nuv <= $signed({r_det[ACC_W-1], r_det}))
                      && !r_nt[ACC_W-1] && (r_nt != '0);
    assign o_stat.ovf  = {{(DIST_W-FRAC_W){1'b0}}, r_nt} >= {r_det, {(QINT_W){1'b0}}};
    assign o_stat.last = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < N_REGS; k++) r_cfg[k] <= '0;
        end else if (cfg_wr && cfg_idx < 3'(N_REGS)) begin
            r_cfg[cfg_idx] <= pwdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_e1[0] <= EDGE_W'(i_b_x) - EDGE_W'(i_a_x);
            r_e1[1] <= EDGE_W'(i_b_y) - EDGE_W'(i_a_y);
            r_e1[2] <= EDGE_W'(i_b_z) - EDGE_W'(i_a_z);
            r_e2[0] <= EDGE_W'(i_c_x) - EDGE_W'(i_a_x);
            r_e2[1] <= EDGE_W'(i_c_y) - EDGE_W'(i_a_y);
            r_e2[2] <= EDGE_W'(i_c_z) - EDGE_W'(i_a_z);
            r_s[0]  <= EDGE_W'(r_cfg[0]) - EDGE_W'(i_a_x);
            r_s[1]  <= EDGE_W'(r_cfg[1]) - EDGE_W'(i_a_y);
            r_s[2]  <= EDGE_W'(r_cfg[2]) - EDGE_W'(i_a_z);
            r_last  <= i_last_triangle;
        end
        if (i_cmd.mul_hi) begin
            r_pacc <= PACC_W'(xm * ym[EDGE_W-1:YLO_W]);
        end
        if (i_cmd.mul_lo) begin
            r_prod <= {r_pacc, {YLO_W{1'b0}}} + PROD_W'(xm * ym[YLO_W-1:0]);
            r_neg  <= xv[WIDE_W-1] ^ yv[EDGE_W-1] ^ uop.sub;
        end
        if (i_cmd.acc) begin
            r_acc <= acc_n;
            case (uop.dst)
                DST_H0:  r_h[0] <= acc_n[WIDE_W-1:0];
                DST_H1:  r_h[1] <= acc_n[WIDE_W-1:0];
                DST_H2:  r_h[2] <= acc_n[WIDE_W-1:0];
                DST_Q0:  r_q[0] <= acc_n[WIDE_W-1:0];
                DST_Q1:  r_q[1] <= acc_n[WIDE_W-1:0];
                DST_Q2:  r_q[2] <= acc_n[WIDE_W-1:0];
                DST_DET: r_det  <= acc_n;
                DST_NU:  r_nu   <= acc_n;
                DST_NV:  r_nv   <= acc_n;
                DST_NT:  r_nt   <= acc_n;
                default: ;
            endcase
        end
        if (i_cmd.flip && r_det[ACC_W-1]) begin
            r_det <= -r_det;
            r_nu  <= -r_nu;
            r_nv  <= -r_nv;
            r_nt  <= -r_nt;
        end
        if (i_cmd.div_init) begin
            r_rem <= ACC_W'(r_nt >>> QINT_W);
            r_dvd <= {r_nt[QINT_W-1:0], {FRAC_W{1'b0}}};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_r2 - r_det : div_r2;
            r_dvd <= {r_dvd[DIST_W-2:0], 1'b0};
            r_quo <= {r_quo[DIST_W-2:0], div_ge};
        end else if (i_cmd.sat) begin
            r_quo <= '1;
        end
        if (i_cmd.emit) begin
            o_hit      <= r_found;
            o_distance <= r_found ? r_best[DIST_W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.emit) begin
            r_best  <= '0;
            r_found <= 1'b0;
        end else if (i_cmd.update) begin
            if (!r_found || {1'b0, r_quo} < r_best) begin
                r_best <= {1'b0, r_quo};
            end
            r_found <= 1'b1;
        end
    end

endmodule

`default_nettype wire

[design/nrth_ctrl.sv]
// ============================================================================
// nrth_ctrl
// Sequencer: input/output handshakes, multiply steps, test and divide
// phases, result hand-off.
// ============================================================================
`default_nettype none

module nrth_ctrl import nrth_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_ready,
    output logic      o_valid,
    input  wire       i_ready,
    output t_dp_cmd   o_cmd,
    input  wire t_dp_stat i_stat
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_HI, S_MUL_LO, S_ACC, S_FLIP, S_CHECK, S_DIV, S_UPD, S_FIN
    } t_state;

    t_state              r_state, n_state;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [DIVC_W-1:0]   r_divc, n_divc;
    logic                r_out_valid, n_out_valid;
    logic                emit_ok;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign emit_ok = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_divc      = r_divc;
        n_out_valid = r_out_valid && !i_ready;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_MUL_HI;
                end
            end
            S_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
                n_state      = S_MUL_LO;
            end
            S_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
                n_state      = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_step == STEP_W'(N_STEPS - 1)) begin
                    n_state = S_FLIP;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_state = S_MUL_HI;
                end
            end
            S_FLIP: begin
                o_cmd.flip = 1'b1;
                n_state    = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.pass) begin
                    n_state = S_FIN;
                end else if (i_stat.ovf) begin
                    o_cmd.sat = 1'b1;
                    n_state   = S_UPD;
                end else begin
                    o_cmd.div_init = 1'b1;
                    n_divc         = '0;
                    n_state        = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_divc         = r_divc + 1'b1;
                if (r_divc == DIVC_W'(DIST_W - 1)) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_FIN;
            end
            S_FIN: begin
                if (!i_stat.last) begin
                    n_state = S_IDLE;
                end else if (emit_ok) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_divc      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_divc      <= n_divc;
            r_out_valid <= n_out_valid;
        end
    end

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL_HI || r_state == S_MUL_LO || r_state == S_ACC)
        |-> (r_step < STEP_W'(N_STEPS)))
        else $error("multiply step out of range");

    a_emit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || i_ready))
        else $error("result overwritten while pending");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> r_out_valid)
        else $error("emitted result not presented");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_MUL_HI && r_step == '0))
        else $error("accepted transaction did not start sequence");

endmodule

`default_nettype wire

[design/nearest_ray_triangle_hit_core.sv]
// ============================================================================
// nearest_ray_triangle_hit_core
// Nearest ray/triangle hit search over a stream of triangles.
// ============================================================================
// Usage:
//  - Program the ray origin and direction (signed Q16.16) over the APB port
//    at byte addresses 0x00..0x14 while the core is idle.
//  - Triangles arrive one per input transaction (i_valid/o_ready). Each one
//    runs through 24 products on a shared two-pass multiplier, a sign/test
//    phase and, on a hit that does not saturate, a restoring divide.
//  - A triangle occupies the core until its sequence ends; o_ready is high
//    only between triangles, so the next triangle is not taken before the
//    core is through with the last one.
//  - The transaction flagged i_last_triangle produces one result
//    (o_valid/i_ready) carrying the hit flag and the nearest distance,
//    then the tracked state clears for the next mesh.
//  - The result sits in an output register; the next mesh is accepted
//    while it waits. Only a second last-triangle result stalls the
//    sequencer until the first is taken.
//  - Synchronous active-low reset clears the ray registers to zero, the
//    tracked hit and the handshakes.
// ============================================================================
`default_nettype none

module nearest_ray_triangle_hit_core import nrth_pkg::*; (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire        [ADDR_W-1:0]   paddr,
    input  wire        [DATA_W-1:0]   pwdata,
    output logic       [DATA_W-1:0]   prdata,
    output logic                      pready,
    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire signed [COORD_W-1:0]  i_a_x,
    input  wire signed [COORD_W-1:0]  i_a_y,
    input  wire signed [COORD_W-1:0]  i_a_z,
    input  wire signed [COORD_W-1:0]  i_b_x,
    input  wire signed [COORD_W-1:0]  i_b_y,
    input  wire signed [COORD_W-1:0]  i_b_z,
    input  wire signed [COORD_W-1:0]  i_c_x,
    input  wire signed [COORD_W-1:0]  i_c_y,
    input  wire signed [COORD_W-1:0]  i_c_z,
    input  wire                       i_last_triangle,
    output logic                      o_valid,
    input  wire                       i_ready,
    output logic                      o_hit,
    output logic       [DIST_W-1:0]   o_distance
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign pready = 1'b1;

    nrth_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    nrth_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .i_a_x           (i_a_x),
        .i_a_y           (i_a_y),
        .i_a_z           (i_a_z),
        .i_b_x           (i_b_x),
        .i_b_y           (i_b_y),
        .i_b_z           (i_b_z),
        .i_c_x           (i_c_x),
        .i_c_y           (i_c_y),
        .i_c_z           (i_c_z),
        .i_last_triangle (i_last_triangle),
        .o_hit           (o_hit),
        .o_distance      (o_distance)
    );

endmodule

`default_nettype wire
